// File: hdl/rpxe_pkg.sv
// Shared constants, types and the arctangent table for the point rotator.
package rpxe_pkg;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_ANGLE_X = 2'd0,
		REG_ANGLE_Y = 2'd1,
		REG_ANGLE_Z = 2'd2
	} reg_idx_t;

	// Trig unit sequencer states
	typedef enum logic [1:0] {
		TRIG_IDLE,
		TRIG_LOAD,
		TRIG_RUN,
		TRIG_DONE
	} trig_state_t;

	localparam int ANGLE_BITS = 16;
	localparam int CORD_W     = 34;   // CORDIC x, y and z width, Q30
	localparam int STEP_W     = 5;    // index into the arctangent table
	localparam int FOLD_W     = 14;   // reduced angle, within +-5760
	localparam int FULL_TURN  = 23040;
	localparam int HALF_TURN  = 11520;
	localparam int QUART_TURN = 5760;
	localparam logic [29:0] DEG_RAD_Q40 = 30'd299845282;
	localparam logic signed [CORD_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// arctan(2^-i) in Q30
	function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd7;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/rpxe_trig.sv
// Iterative CORDIC unit: sine and cosine of the three angle registers.
module rpxe_trig import rpxe_pkg::*; #(
	parameter int TRIG_BITS    = 18,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_addr,
	input  logic [ANGLE_BITS-1:0]       cfg_wdata,
	output logic                        busy,
	output logic signed [TRIG_BITS-1:0] sin_v [3],
	output logic signed [TRIG_BITS-1:0] cos_v [3]
);

	localparam int RS = 32 - TRIG_BITS;
	localparam logic signed [CORD_W-1:0] RHALF =
		(RS > 0) ? (CORD_W'(1) << ((RS > 0) ? RS - 1 : 0)) : '0;
	localparam logic signed [CORD_W-1:0] TMAX = (CORD_W'(1) << (TRIG_BITS - 1)) - 1;
	localparam logic signed [CORD_W-1:0] TMIN = -TMAX - 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
	localparam logic signed [ANGLE_BITS:0] FULL_A  = (ANGLE_BITS + 1)'(FULL_TURN);
	localparam logic signed [ANGLE_BITS:0] HALF_A  = (ANGLE_BITS + 1)'(HALF_TURN);

	trig_state_t state_q, state_d;
	logic [ANGLE_BITS-1:0] angle_q [3];
	logic [2:0] pend_q, set_w, clr_w;
	logic [1:0] axis_q, axis_d;
	logic signed [FOLD_W-1:0] fold_q;
	logic flip_q;
	logic [STEP_W-1:0] step_q;
	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [ANGLE_BITS:0] ar;
	logic fold_flip;
	logic signed [43:0] rad;
	logic signed [CORD_W-1:0] dx, dy, atn, xr, yr;

	assign busy = (state_q != TRIG_IDLE) || (pend_q != 3'b000);

	// Mark the written axis for recompute
	always_comb begin
		set_w = 3'b000;
		if (cfg_we) begin
			unique case (cfg_addr)
				REG_ANGLE_X: set_w = 3'b001;
				REG_ANGLE_Y: set_w = 3'b010;
				REG_ANGLE_Z: set_w = 3'b100;
				default:     set_w = 3'b000;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) angle_q[k] <= '0;
		end else if (set_w != 3'b000) begin
			angle_q[cfg_addr] <= cfg_wdata;
		end
	end

	// Pick the lowest pending axis
	always_comb begin
		priority if (pend_q[0]) axis_d = 2'd0;
		else if (pend_q[1])     axis_d = 2'd1;
		else                    axis_d = 2'd2;
	end

	// Wrap the angle to one turn and fold into +-90 degrees
	always_comb begin
		ar = {angle_q[axis_d][ANGLE_BITS-1], angle_q[axis_d]};
		fold_flip = 1'b0;
		if (ar >= FULL_TURN) ar = ar - FULL_A;
		else if (ar <= -FULL_TURN) ar = ar + FULL_A;
		if (ar < 0) ar = ar + FULL_A;
		if (ar > HALF_TURN) ar = ar - FULL_A;
		if (ar > QUART_TURN) begin
			ar = ar - HALF_A;
			fold_flip = 1'b1;
		end else if (ar < -QUART_TURN) begin
			ar = ar + HALF_A;
			fold_flip = 1'b1;
		end
	end

	// Sequencer next state; drop the pending mark once the angle is captured
	always_comb begin
		state_d = state_q;
		clr_w = 3'b000;
		unique case (state_q)
			TRIG_IDLE: begin
				if (pend_q != 3'b000) begin
					state_d = TRIG_LOAD;
					clr_w[axis_d] = 1'b1;
				end
			end
			TRIG_LOAD: state_d = TRIG_RUN;
			TRIG_RUN:  if (step_q == LAST_STEP) state_d = TRIG_DONE;
			TRIG_DONE: state_d = TRIG_IDLE;
			default:   state_d = TRIG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TRIG_IDLE;
			pend_q  <= 3'b000;
		end else begin
			state_q <= state_d;
			pend_q  <= (pend_q & ~clr_w) | set_w;
		end
	end

	// CORDIC datapath
	assign rad = fold_q * $signed({14'd0, DEG_RAD_Q40});
	assign dx  = y_q >>> step_q;
	assign dy  = x_q >>> step_q;
	assign atn = CORD_W'(atan_q30(step_q));

	always_ff @(posedge clk) begin
		unique case (state_q)
			TRIG_IDLE: begin
				axis_q <= axis_d;
				fold_q <= FOLD_W'(ar);
				flip_q <= fold_flip;
				step_q <= '0;
			end
			TRIG_LOAD: begin
				x_q <= CORDIC_GAIN_Q30;
				y_q <= '0;
				z_q <= CORD_W'((rad + 44'sd512) >>> 10);
			end
			TRIG_RUN: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atn;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atn;
				end
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Round to trig precision, unfold and clamp
	always_comb begin
		xr = (x_q + RHALF) >>> RS;
		yr = (y_q + RHALF) >>> RS;
		if (flip_q) begin
			xr = -xr;
			yr = -yr;
		end
		if (xr > TMAX) xr = TMAX;
		else if (xr < TMIN) xr = TMIN;
		if (yr > TMAX) yr = TMAX;
		else if (yr < TMIN) yr = TMIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				sin_v[k] <= '0;
				cos_v[k] <= TRIG_BITS'(1) << (TRIG_BITS - 2);
			end
		end else if (state_q == TRIG_DONE) begin
			sin_v[axis_q] <= TRIG_BITS'(yr);
			cos_v[axis_q] <= TRIG_BITS'(xr);
		end
	end

endmodule

// File: hdl/rpxe_rot.sv
// One plane rotation: a' = c*a + s*b, b' = -s*a + c*b, two pipeline stages.
module rpxe_rot import rpxe_pkg::*; #(
	parameter int W = 27,
	parameter int T = 18
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  logic signed [W-1:0] pass,
	input  logic signed [T-1:0] c,
	input  logic signed [T-1:0] s,
	output logic signed [W-1:0] out_a,
	output logic signed [W-1:0] out_b,
	output logic signed [W-1:0] out_pass
);

	localparam int PW = W + T;
	localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (T - 3);

	logic v_s1, v_s2, en_s1, en_s2;
	logic signed [PW-1:0] pca_s1, psb_s1, psa_s1, pcb_s1;
	logic signed [W-1:0] pass_s1;
	logic signed [PW:0] sum_a, sum_b;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
		end
	end

	// Form the four products
	always_ff @(posedge clk) begin
		if (en_s1) begin
			pca_s1  <= c * a;
			psb_s1  <= s * b;
			psa_s1  <= s * a;
			pcb_s1  <= c * b;
			pass_s1 <= pass;
		end
	end

	// Sum, round half up and drop the fraction bits of the trig values
	assign sum_a = (PW + 1)'(pca_s1) + (PW + 1)'(psb_s1) + HALF;
	assign sum_b = (PW + 1)'(pcb_s1) - (PW + 1)'(psa_s1) + HALF;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			out_a    <= W'(sum_a >>> (T - 2));
			out_b    <= W'(sum_b >>> (T - 2));
			out_pass <= pass_s1;
		end
	end

endmodule

// File: hdl/rpxe_sat.sv
// Output stage: saturate the three components and flag clipping.
module rpxe_sat import rpxe_pkg::*; #(
	parameter int W  = 27,
	parameter int CW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic signed [W-1:0]  x,
	input  logic signed [W-1:0]  y,
	input  logic signed [W-1:0]  z,
	output logic signed [CW-1:0] out_x,
	output logic signed [CW-1:0] out_y,
	output logic signed [CW-1:0] out_z,
	output logic                 clipped
);

	localparam logic signed [W-1:0] CMAX = (W'(1) << (CW - 1)) - W'(1);
	localparam logic signed [W-1:0] CMIN = -CMAX - W'(1);

	logic en_q;
	logic hx, hy, hz;
	logic signed [W-1:0] cx, cy, cz;

	assign en_q     = !out_valid || out_ready;
	assign in_ready = en_q;

	// Clamp each component
	always_comb begin
		hx = (x > CMAX) || (x < CMIN);
		hy = (y > CMAX) || (y < CMIN);
		hz = (z > CMAX) || (z < CMIN);
		cx = (x > CMAX) ? CMAX : ((x < CMIN) ? CMIN : x);
		cy = (y > CMAX) ? CMAX : ((y < CMIN) ? CMIN : y);
		cz = (z > CMAX) ? CMAX : ((z < CMIN) ? CMIN : z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en_q) out_valid <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en_q) begin
			out_x   <= CW'(cx);
			out_y   <= CW'(cy);
			out_z   <= CW'(cz);
			clipped <= hx || hy || hz;
		end
	end

endmodule

// File: hdl/rotate_points_xyz_euler.sv
// Top level: streaming 3D point rotator about X, then Y, then Z.
//
// Usage:
//   Points enter on s_tvalid/s_tready/s_tdata as {in_z, in_y, in_x}, each a
//   signed Q.12 coordinate of COORD_BITS. Results leave on m_tvalid/m_tready
//   with m_tdata = {out_z, out_y, out_x} and m_tuser = clipped.
//   Angles are written on cfg_we/cfg_addr/cfg_wdata (0 = X, 1 = Y, 2 = Z),
//   in 1/64 degree. Each write recomputes that axis by an iterative CORDIC,
//   one step per cycle; s_tready stays low until every pending axis is done.
//   Each axis rotation has two stages (products, then sum and round), and
//   one saturation stage follows. One point is accepted per cycle unless an
//   axis is pending or m_tready stalls. Every stage holds its item while the
//   next is full; a stall backs up stage by stage, filling empty stages first.
//   Reset clears all angles (sines 0, cosines 1) and empties the pipeline.
module rotate_points_xyz_euler import rpxe_pkg::*; #(
	parameter int COORD_BITS   = 24,
	parameter int TRIG_BITS    = 18,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((3 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,  // in_x, in_y, in_z
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [((3 * COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,  // out_x, out_y, out_z
	output logic                                      m_tuser,  // clipped
	input  logic                                      cfg_we,
	input  logic [1:0]                                cfg_addr,
	input  logic [ANGLE_BITS-1:0]                     cfg_wdata
);

	localparam int CW = COORD_BITS;
	localparam int W  = COORD_BITS + 3;
	localparam int DW = ((3 * COORD_BITS + 7) / 8) * 8;

	logic busy;
	logic signed [TRIG_BITS-1:0] sin_v [3];
	logic signed [TRIG_BITS-1:0] cos_v [3];
	logic signed [W-1:0] ix, iy, iz;
	logic signed [W-1:0] y1, z1, x1, x2, z2, y2, x3, y3, z3;
	logic rdy1, rdy2, rdy3, rdy4, v1, v2, v3;
	logic signed [CW-1:0] ox, oy, oz;

	rpxe_trig #(.TRIG_BITS(TRIG_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_trig (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata), .busy(busy), .sin_v(sin_v), .cos_v(cos_v)
	);

	// Unpack and sign-extend the input item
	assign ix = W'($signed(s_tdata[CW-1:0]));
	assign iy = W'($signed(s_tdata[2*CW-1:CW]));
	assign iz = W'($signed(s_tdata[3*CW-1:2*CW]));
	assign s_tready = rdy1 && !busy;

	// About X: rotate (y, z)
	rpxe_rot #(.W(W), .T(TRIG_BITS)) u_rot_x (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid && !busy), .in_ready(rdy1),
		.out_valid(v1), .out_ready(rdy2), .a(iy), .b(iz), .pass(ix),
		.c(cos_v[0]), .s(sin_v[0]), .out_a(y1), .out_b(z1), .out_pass(x1)
	);

	// About Y: rotate (x, z)
	rpxe_rot #(.W(W), .T(TRIG_BITS)) u_rot_y (
		.clk(clk), .arst_n(arst_n), .in_valid(v1), .in_ready(rdy2),
		.out_valid(v2), .out_ready(rdy3), .a(x1), .b(z1), .pass(y1),
		.c(cos_v[1]), .s(sin_v[1]), .out_a(x2), .out_b(z2), .out_pass(y2)
	);

	// About Z: rotate (x, y)
	rpxe_rot #(.W(W), .T(TRIG_BITS)) u_rot_z (
		.clk(clk), .arst_n(arst_n), .in_valid(v2), .in_ready(rdy3),
		.out_valid(v3), .out_ready(rdy4), .a(x2), .b(y2), .pass(z2),
		.c(cos_v[2]), .s(sin_v[2]), .out_a(x3), .out_b(y3), .out_pass(z3)
	);

	rpxe_sat #(.W(W), .CW(CW)) u_sat (
		.clk(clk), .arst_n(arst_n), .in_valid(v3), .in_ready(rdy4),
		.out_valid(m_tvalid), .out_ready(m_tready), .x(x3), .y(y3), .z(z3),
		.out_x(ox), .out_y(oy), .out_z(oz), .clipped(m_tuser)
	);

	// Pack the result item
	assign m_tdata = DW'({oz, oy, ox});

endmodule

// File: dv/rotate_points_xyz_euler_test.sv
// Self-checking stream testbench for the Euler-angle point rotator.
module rotate_points_xyz_euler_test;
	import rpxe_pkg::*;

	localparam int CB = 24;
	localparam int TB = 18;
	localparam int STEPS = 16;
	localparam int DW = ((3 * CB + 7) / 8) * 8;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic signed [CB-1:0] z;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] x;
	} point_t;

	typedef struct {
		point_t p;
		logic   clipped;
	} rotated_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DW-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = REG_ANGLE_X;
	logic [ANGLE_BITS-1:0] cfg_wdata = '0;

	// predictor state: {sin, cos} per axis, Q(TB-2)
	longint trig_sin[3];
	longint trig_cos[3];

	point_t pending_points[$];
	rotated_t expected_points[$];
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold = 1'b0;
	bit send_pause = 1'b0;
	int errors = 0;
	int idle_cycles = 0;

	rotate_points_xyz_euler dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	// CORDIC sine/cosine of one angle in 1/64 degree
	task automatic update_trig(int axis, logic [15:0] raw);
		longint a, x, y, z, dx, dy;
		bit flip;
		int s;
		a = longint'($signed(raw)) % 23040;
		flip = 1'b0;
		s = 32 - TB;
		if (a < 0) a += 23040;
		if (a > 11520) a -= 23040;
		if (a > 5760) begin
			a -= 11520;
			flip = 1'b1;
		end else if (a < -5760) begin
			a += 11520;
			flip = 1'b1;
		end
		z = fshift(a * 64'sd299845282 + 512, 10);
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_q30(i[4:0]));
			end else begin
				x += dx; y -= dy; z += longint'(atan_q30(i[4:0]));
			end
		end
		x = fshift(x + (64'sd1 <<< (s - 1)), s);
		y = fshift(y + (64'sd1 <<< (s - 1)), s);
		if (flip) begin
			x = -x; y = -y;
		end
		if (x > (1 <<< (TB - 1)) - 1) x = (1 <<< (TB - 1)) - 1;
		if (x < -(1 <<< (TB - 1))) x = -(1 <<< (TB - 1));
		if (y > (1 <<< (TB - 1)) - 1) y = (1 <<< (TB - 1)) - 1;
		if (y < -(1 <<< (TB - 1))) y = -(1 <<< (TB - 1));
		trig_sin[axis] = y;
		trig_cos[axis] = x;
	endtask

	function automatic logic signed [127:0] dot_q(longint c, longint u, longint s, longint v);
		logic signed [127:0] acc;
		acc = 128'(c) * 128'(u) + 128'(s) * 128'(v) + (128'sd1 <<< (TB - 3));
		return acc >>> (TB - 2);
	endfunction

	function automatic longint sat(logic signed [127:0] v, ref bit hit);
		if (v > (128'sd1 <<< (CB - 1)) - 1) begin
			hit = 1'b1; return (64'sd1 <<< (CB - 1)) - 1;
		end
		if (v < -(128'sd1 <<< (CB - 1))) begin
			hit = 1'b1; return -(64'sd1 <<< (CB - 1));
		end
		return longint'(v);
	endfunction

	function automatic rotated_t rotate_point(point_t p);
		logic signed [127:0] x, y, z, t1, t2;
		rotated_t r;
		bit hit;
		hit = 1'b0;
		x = p.x; y = p.y; z = p.z;
		t1 = dot_q(trig_cos[0], y, trig_sin[0], z);
		t2 = dot_q(-trig_sin[0], y, trig_cos[0], z);
		y = t1; z = t2;
		t1 = dot_q(trig_cos[1], x, trig_sin[1], z);
		t2 = dot_q(-trig_sin[1], x, trig_cos[1], z);
		x = t1; z = t2;
		t1 = dot_q(trig_cos[2], x, trig_sin[2], y);
		t2 = dot_q(-trig_sin[2], x, trig_cos[2], y);
		x = t1; y = t2;
		r.p.x = CB'(sat(x, hit));
		r.p.y = CB'(sat(y, hit));
		r.p.z = CB'(sat(z, hit));
		r.clipped = hit;
		return r;
	endfunction

	// drive items from the pending queue, predicting on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				expected_points.push_back(rotate_point(point_t'(s_tdata[3*CB-1:0])));
				void'(pending_points.pop_front());
			end
			if (!send_pause && pending_points.size() > 0 &&
			    ((s_tvalid && !s_tready) || $urandom_range(99) >= send_idle_pct)) begin
				s_tdata <= DW'(pending_points[0]);
				s_tvalid <= 1'b1;
			end else if (!(s_tvalid && !s_tready)) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// randomize ready and compare accepted results
	always @(posedge clk) begin
		rotated_t e;
		point_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = point_t'(m_tdata[3*CB-1:0]);
				if (expected_points.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $time, m_tdata);
				end else begin
					e = expected_points.pop_front();
					if (got.x !== e.p.x || got.y !== e.p.y || got.z !== e.p.z ||
					    m_tuser !== e.clipped) begin
						errors++;
						$display("%0t: expected %h/%b actual %h/%b", $time, e.p, e.clipped,
							got, m_tuser);
					end
				end
			end
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || recv_hold)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [CB-1:0] rand_coord();
		case ($urandom_range(5))
			0: return {1'b0, {(CB-1){1'b1}}};
			1: return {1'b1, {(CB-1){1'b0}}};
			2: return CB'($signed($urandom_range(8192)) - 4096);
			default: return CB'($urandom);
		endcase
	endfunction

	task automatic add_point(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z);
		point_t p;
		p.x = x; p.y = y; p.z = z;
		pending_points.push_back(p);
	endtask

	task automatic wait_drained();
		while (pending_points.size() > 0 || s_tvalid || expected_points.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic wait_drained_results();
		while (expected_points.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// write one angle while the pipeline is empty
	task automatic write_angle(reg_idx_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		update_trig(int'(idx), val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_points(int n);
		for (int i = 0; i < n; i++) add_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic random_angles();
		write_angle(REG_ANGLE_X, 16'($urandom_range(46080) - 23040));
		write_angle(REG_ANGLE_Y, 16'($urandom));
		write_angle(REG_ANGLE_Z, 16'($urandom_range(46080) - 23040));
	endtask

	initial begin
		for (int k = 0; k < 3; k++) begin
			trig_sin[k] = 0;
			trig_cos[k] = 64'sd1 <<< (TB - 2);
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity rotation with extreme coordinates
		add_point('0, '0, '0);
		add_point({1'b0, {(CB-1){1'b1}}}, {1'b1, {(CB-1){1'b0}}}, 24'h001000);
		add_point({CB{1'b1}}, 24'h555555, 24'hAAAAAA);
		wait_drained();

		// directed angles: quadrants, folds, full turn extremes, wraps
		write_angle(REG_ANGLE_X, 16'd5760);
		write_angle(REG_ANGLE_Y, 16'd11520);
		write_angle(REG_ANGLE_Z, -16'sd23040);
		add_point(24'h001000, 24'h002000, 24'h003000);
		add_point({1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}});
		add_point({1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}});
		wait_drained();
		write_angle(REG_ANGLE_X, 16'd23040);
		write_angle(REG_ANGLE_Y, -16'sd5761);
		write_angle(REG_ANGLE_Z, 16'h7FFF);
		add_point(24'h7FF000, 24'h800000, 24'h012345);
		add_point(24'hFFFFFF, 24'h000001, 24'h400000);
		wait_drained();
		write_angle(REG_ANGLE_X, 16'h8000);
		write_angle(REG_ANGLE_Y, 16'd2880);
		write_angle(REG_ANGLE_Z, -16'sd11519);
		add_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
		add_point(24'h000800, 24'hFFF800, 24'h000000);
		wait_drained();

		// random phases across the three idling profiles
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = (ph < 4) ? 27 : (ph < 8) ? 47 : 0;
			recv_idle_pct = (ph < 4) ? 47 : (ph < 8) ? 27 : 0;
			random_angles();
			random_points(100);
			if (ph == 9) begin
				// hold the receiver off so the pipeline backs up
				fork
					begin
						recv_hold = 1'b1;
						repeat (60) @(posedge clk);
						recv_hold = 1'b0;
					end
				join_none
			end
			wait_drained();
		end

		// sender pause: stop mid-stream until every result is out, then resume
		random_points(40);
		repeat (15) @(posedge clk);
		send_pause = 1'b1;
		wait_drained_results();
		send_pause = 1'b0;
		wait_drained();

		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

// File: rotate_points_xyz_euler.f
hdl/rpxe_pkg.sv
hdl/rpxe_trig.sv
hdl/rpxe_rot.sv
hdl/rpxe_sat.sv
hdl/rotate_points_xyz_euler.sv
dv/rotate_points_xyz_euler_test.sv
